>>> sv/fast_segment_corner_test_core_assert.svh
// Assertion macros shared by the corner test RTL.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef FAST_SEGMENT_CORNER_TEST_CORE_ASSERT_SVH
`define FAST_SEGMENT_CORNER_TEST_CORE_ASSERT_SVH

// same-cycle implication
`define FSCT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FSCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/fsct_pkg.sv
// Shared constants, types and circle geometry for the segment corner test.
// No dependencies; used by every module of the block except fsct_ram.
`timescale 1ns / 1ps
`default_nettype none

package fsct_pkg;

    localparam int MAX_WIDTH     = 4096;
    localparam int PIXEL_BITS    = 16;
    localparam int ARC_LENGTH    = 12;
    localparam int FRAC_BITS     = 16;

    localparam int CIRCLE_POINTS = 16;
    localparam int RADIUS        = 3;
    localparam int WIN           = 2 * RADIUS + 1;
    localparam int LINES         = WIN - 1;
    localparam int MIN_WIDTH     = WIN;

    localparam int X_W           = $clog2(MAX_WIDTH);
    localparam int WIDTH_W       = 13;
    localparam int ROW_W         = 16;
    localparam int CX_W          = 12;
    localparam int THR_W         = 16;
    localparam int LEVEL_W       = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int IN_DATA_W     = 16;
    localparam int OUT_DATA_W    = 32;
    localparam int LINE_WORD_W   = LINES * PIXEL_BITS;
    localparam int FAC_W         = FRAC_BITS + 1;
    localparam int PROD_W        = PIXEL_BITS + FAC_W;

    localparam logic [WIDTH_W-1:0] IMAGE_WIDTH_RST = WIDTH_W'(640);
    localparam logic [THR_W-1:0]   THRESHOLD_RST   = THR_W'(6554);
    localparam logic [LEVEL_W-1:0] MIN_LEVEL_RST   = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH = 2'd0,
        REG_THRESHOLD   = 2'd1,
        REG_MIN_LEVEL   = 2'd2
    } cfg_reg_t;

    // window row / column of each circle point, clockwise from just left of top
    localparam int CIRCLE_ROW [CIRCLE_POINTS] =
        '{0, 0, 0, 1, 2, 3, 4, 5, 6, 6, 6, 5, 4, 3, 2, 1};
    localparam int CIRCLE_COL [CIRCLE_POINTS] =
        '{2, 3, 4, 5, 6, 6, 6, 5, 4, 3, 2, 1, 0, 0, 0, 1};

    typedef struct packed {
        logic               center_valid;
        logic [CX_W-1:0]    center_x;
        logic [ROW_W-1:0]   center_y;
    } meta_t;

    typedef struct packed {
        logic [X_W-1:0]         x;
        logic [PIXEL_BITS-1:0]  pixel;
        meta_t                  meta;
    } pix_item_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0]                      center;
        logic [CIRCLE_POINTS-1:0][PIXEL_BITS-1:0]   ring;
    } circle_t;

endpackage

`default_nettype wire

>>> sv/fsct_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fsct_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> sv/fsct_window.sv
// Line stores and 7x7 window: one RAM word per column holds the six stored lines.
// Depends on fsct_pkg and fsct_ram.
`timescale 1ns / 1ps
`default_nettype none

module fsct_window (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  fsct_pkg::pix_item_t in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output fsct_pkg::circle_t   out_circle,
    output fsct_pkg::meta_t     out_meta
);

    localparam int PB  = fsct_pkg::PIXEL_BITS;
    localparam int LW  = fsct_pkg::LINE_WORD_W;
    localparam int WN  = fsct_pkg::WIN;
    localparam int LN  = fsct_pkg::LINES;

    logic                s1_valid_reg;
    fsct_pkg::pix_item_t s1_item_reg;
    logic                s1_fwd_reg;
    logic [LW-1:0]       last_word_reg;

    logic                out_valid_reg;
    fsct_pkg::circle_t   circle_reg;
    fsct_pkg::meta_t     meta_reg;

    logic [PB-1:0]       win_reg  [WN][WN];
    logic [PB-1:0]       win_next [WN][WN];
    logic [PB-1:0]       col_pix  [WN];
    fsct_pkg::circle_t   circle_next;

    logic [LW-1:0]       ram_rdata;
    logic [LW-1:0]       old_word;
    logic [LW-1:0]       new_word;

    logic                s1_adv;
    logic                s1_fire;
    logic                in_fire;

    assign s1_adv   = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && s1_adv;
    assign in_ready = !s1_valid_reg || s1_adv;
    assign in_fire  = in_valid && in_ready;

    // column word is read at accept and written back when the item leaves stage 1
    fsct_ram #(
        .WIDTH (LW),
        .DEPTH (fsct_pkg::MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (s1_fire),
        .waddr (s1_item_reg.x),
        .wdata (new_word),
        .re    (in_fire),
        .raddr (in_item.x),
        .rdata (ram_rdata)
    );

    // back-to-back hit on the same column: take the word just written
    assign old_word = s1_fwd_reg ? last_word_reg : ram_rdata;
    assign new_word = {old_word[LW-PB-1:0], s1_item_reg.pixel};

    always_comb
    begin
        for (int r = 0; r < LN; r++)
        begin
            col_pix[r] = old_word[(LN-1-r)*PB +: PB];
        end
        col_pix[WN-1] = s1_item_reg.pixel;
        for (int r = 0; r < WN; r++)
        begin
            for (int c = 0; c < WN - 1; c++)
            begin
                win_next[r][c] = win_reg[r][c+1];
            end
            win_next[r][WN-1] = col_pix[r];
        end
        circle_next.center = win_next[fsct_pkg::RADIUS][fsct_pkg::RADIUS];
        for (int k = 0; k < fsct_pkg::CIRCLE_POINTS; k++)
        begin
            circle_next.ring[k] =
                win_next[fsct_pkg::CIRCLE_ROW[k]][fsct_pkg::CIRCLE_COL[k]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_item_reg <= in_item;
            s1_fwd_reg  <= s1_fire && (s1_item_reg.x == in_item.x);
        end
        if (s1_fire)
        begin
            last_word_reg <= new_word;
            win_reg       <= win_next;
            circle_reg    <= circle_next;
            meta_reg      <= s1_item_reg.meta;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_circle = circle_reg;
    assign out_meta   = meta_reg;

endmodule

`default_nettype wire

>>> sv/fsct_seg.sv
// Segment test pipeline: threshold products, per-point class compares, arc search.
// Depends on fsct_pkg. Last stage is the block's output register.
`timescale 1ns / 1ps
`default_nettype none

module fsct_seg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  fsct_pkg::circle_t                   in_circle,
    input  fsct_pkg::meta_t                     in_meta,
    input  logic [fsct_pkg::THR_W-1:0]          threshold_frac,
    input  logic [fsct_pkg::LEVEL_W-1:0]        min_level,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                out_is_corner,
    output fsct_pkg::meta_t                     out_meta
);

    localparam int PB  = fsct_pkg::PIXEL_BITS;
    localparam int NP  = fsct_pkg::CIRCLE_POINTS;
    localparam int FW  = fsct_pkg::FAC_W;
    localparam int PW  = fsct_pkg::PROD_W;
    localparam logic [FW-1:0] ONE = FW'(1) << fsct_pkg::FRAC_BITS;

    // product stage
    logic                       p_valid_reg;
    logic [NP-1:0][PB-1:0]      p_ring_reg;
    logic [PW-1:0]              p_up_reg;
    logic [PW-1:0]              p_dn_reg;
    logic                       p_below_en_reg;
    logic                       p_level_ok_reg;
    fsct_pkg::meta_t            p_meta_reg;
    // class stage
    logic                       m_valid_reg;
    logic [NP-1:0]              m_above_reg;
    logic [NP-1:0]              m_below_reg;
    logic                       m_level_ok_reg;
    fsct_pkg::meta_t            m_meta_reg;
    // output stage
    logic                       o_valid_reg;
    logic                       o_corner_reg;
    fsct_pkg::meta_t            o_meta_reg;

    logic [FW-1:0]              up_fac;
    logic [FW-1:0]              dn_fac;
    logic                       below_en;
    logic [PW-1:0]              up_prod;
    logic [PW-1:0]              dn_prod;
    logic [PW-1:0]              lhs [NP];
    logic [NP-1:0]              above;
    logic [NP-1:0]              below;
    logic                       run_a;
    logic                       run_b;
    logic                       any_run;

    logic                       o_adv;
    logic                       m_adv;
    logic                       p_adv;

    assign o_adv    = !o_valid_reg || out_ready;
    assign m_adv    = !m_valid_reg || o_adv;
    assign p_adv    = !p_valid_reg || m_adv;
    assign in_ready = p_adv;

    // bounds (1 + t) * p and (1 - t) * p; below is impossible once t reaches 1
    assign up_fac   = ONE + FW'(threshold_frac);
    assign below_en = FW'(threshold_frac) < ONE;
    assign dn_fac   = ONE - FW'(threshold_frac);
    assign up_prod  = PW'(up_fac) * PW'(in_circle.center);
    assign dn_prod  = PW'(dn_fac) * PW'(in_circle.center);

    always_comb
    begin
        for (int k = 0; k < NP; k++)
        begin
            lhs[k]   = PW'({p_ring_reg[k], {fsct_pkg::FRAC_BITS{1'b0}}});
            above[k] = lhs[k] > p_up_reg;
            below[k] = p_below_en_reg && (lhs[k] < p_dn_reg);
        end
    end

    // any circular run of ARC_LENGTH equal non-similar classes
    always_comb
    begin
        any_run = 1'b0;
        for (int s = 0; s < NP; s++)
        begin
            run_a = 1'b1;
            run_b = 1'b1;
            for (int k = 0; k < fsct_pkg::ARC_LENGTH; k++)
            begin
                run_a = run_a && m_above_reg[($clog2(NP))'(s + k)];
                run_b = run_b && m_below_reg[($clog2(NP))'(s + k)];
            end
            any_run = any_run || run_a || run_b;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (p_adv)
            begin
                p_valid_reg <= in_valid;
            end
            if (m_adv)
            begin
                m_valid_reg <= p_valid_reg;
            end
            if (o_adv)
            begin
                o_valid_reg <= m_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && p_adv)
        begin
            p_ring_reg     <= in_circle.ring;
            p_up_reg       <= up_prod;
            p_dn_reg       <= dn_prod;
            p_below_en_reg <= below_en;
            p_level_ok_reg <= in_circle.center >= min_level;
            p_meta_reg     <= in_meta;
        end
        if (p_valid_reg && m_adv)
        begin
            m_above_reg    <= above;
            m_below_reg    <= below;
            m_level_ok_reg <= p_level_ok_reg;
            m_meta_reg     <= p_meta_reg;
        end
        if (m_valid_reg && o_adv)
        begin
            o_corner_reg <= m_meta_reg.center_valid && m_level_ok_reg && any_run;
            o_meta_reg   <= m_meta_reg;
        end
    end

    assign out_valid     = o_valid_reg;
    assign out_is_corner = o_corner_reg;
    assign out_meta      = o_meta_reg;

endmodule

`default_nettype wire

>>> sv/fast_segment_corner_test_core.sv
// Segment-test corner detector on a raster pixel stream (FAST style, 12 of 16).
// Top level: config registers, row/column tracking, window and test pipeline.
// Depends on fsct_pkg, fsct_window, fsct_seg and the assertion macro header.
//
// Usage:
//   s_axis carries one pixel per transfer in raster order; tuser high marks the
//   first pixel of a frame (column 0, row 0). Every input transfer yields exactly
//   one m_axis transfer for the centre three rows up and three columns back.
//   m_axis_tuser is center_valid (window full, centre outside the 3-pixel
//   border); is_corner is only ever set when center_valid is set.
//   cfg writes (index 0 image_width, 1 threshold_frac, 2 min_level) are always
//   accepted; change them only while no pixel is in flight.
// Timing:
//   one pixel per clock sustained while m_axis_tready stays high; a pixel passes
//   the line RAM read, window shift, threshold multiply, class compare, then arc
//   search into the output register before its result appears on m_axis. The
//   line RAM's single read and write port set the one-pixel-per-clock rate.
//   When m_axis_tready is low the pipeline keeps filling its empty stages and
//   then holds s_axis_tready low; nothing is dropped.
// Reset:
//   clears counters, pipeline valids and restores the default registers
//   (width 640, threshold 6554, min level 0). Line RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "fast_segment_corner_test_core_assert.svh"

module fast_segment_corner_test_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [fsct_pkg::IN_DATA_W-1:0]      s_axis_tdata,   // [15:0] pixel
    input  logic                                s_axis_tuser,   // [0] frame_start
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [0] is_corner, [12:1] center_x, [28:13] center_y, [31:29] zero
    output logic [fsct_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tuser,   // [0] center_valid
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [fsct_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fsct_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int XW = fsct_pkg::X_W;
    localparam int WW = fsct_pkg::WIDTH_W;
    localparam int RW = fsct_pkg::ROW_W;

    logic [WW-1:0]                  image_width_reg;
    logic [fsct_pkg::THR_W-1:0]     threshold_reg;
    logic [fsct_pkg::LEVEL_W-1:0]   min_level_reg;
    logic [XW-1:0]                  col_count_reg;
    logic [XW-1:0]                  col_count_next;
    logic [RW-1:0]                  row_count_reg;
    logic [RW-1:0]                  row_count_next;

    logic [WW-1:0]                  eff_w;
    logic [XW-1:0]                  col0;
    logic [RW-1:0]                  row0;
    logic [XW-1:0]                  x;
    logic [RW-1:0]                  y;
    logic [WW-1:0]                  x_inc;
    fsct_pkg::pix_item_t            item;
    logic                           in_fire;

    logic                           win_valid;
    logic                           win_ready;
    fsct_pkg::circle_t              win_circle;
    fsct_pkg::meta_t                win_meta;
    logic                           seg_ready;
    logic                           res_corner;
    fsct_pkg::meta_t                res_meta;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= fsct_pkg::IMAGE_WIDTH_RST;
            threshold_reg   <= fsct_pkg::THRESHOLD_RST;
            min_level_reg   <= fsct_pkg::MIN_LEVEL_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                fsct_pkg::REG_IMAGE_WIDTH: image_width_reg <= cfg_data[WW-1:0];
                fsct_pkg::REG_THRESHOLD:   threshold_reg   <= cfg_data;
                fsct_pkg::REG_MIN_LEVEL:   min_level_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // row / column of the incoming pixel, then the counters for the next one
    always_comb
    begin
        if (image_width_reg < WW'(fsct_pkg::MIN_WIDTH))
        begin
            eff_w = WW'(fsct_pkg::MIN_WIDTH);
        end
        else if (image_width_reg > WW'(fsct_pkg::MAX_WIDTH))
        begin
            eff_w = WW'(fsct_pkg::MAX_WIDTH);
        end
        else
        begin
            eff_w = image_width_reg;
        end

        col0 = s_axis_tuser ? '0 : col_count_reg;
        row0 = s_axis_tuser ? '0 : row_count_reg;
        // width lowered mid-row: wrap to a new row
        if (WW'(col0) >= eff_w)
        begin
            x = '0;
            y = (row0 == '1) ? row0 : row0 + RW'(1);
        end
        else
        begin
            x = col0;
            y = row0;
        end

        x_inc = WW'(x) + WW'(1);
        if (x_inc >= eff_w)
        begin
            col_count_next = '0;
            row_count_next = (y == '1) ? y : y + RW'(1);
        end
        else
        begin
            col_count_next = x_inc[XW-1:0];
            row_count_next = y;
        end

        item.x                 = x;
        item.pixel             = s_axis_tdata[fsct_pkg::PIXEL_BITS-1:0];
        item.meta.center_valid = (x >= XW'(2 * fsct_pkg::RADIUS)) &&
                                 (y >= RW'(2 * fsct_pkg::RADIUS));
        item.meta.center_x     = (x >= XW'(fsct_pkg::RADIUS)) ?
                                 fsct_pkg::CX_W'(x - XW'(fsct_pkg::RADIUS)) : '0;
        item.meta.center_y     = (y >= RW'(fsct_pkg::RADIUS)) ?
                                 y - RW'(fsct_pkg::RADIUS) : '0;
    end

    assign s_axis_tready = win_ready;
    assign in_fire       = s_axis_tvalid && win_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end
        else if (in_fire)
        begin
            col_count_reg <= col_count_next;
            row_count_reg <= row_count_next;
        end
    end

    fsct_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (win_ready),
        .in_item    (item),
        .out_valid  (win_valid),
        .out_ready  (seg_ready),
        .out_circle (win_circle),
        .out_meta   (win_meta)
    );

    fsct_seg u_seg (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (win_valid),
        .in_ready       (seg_ready),
        .in_circle      (win_circle),
        .in_meta        (win_meta),
        .threshold_frac (threshold_reg),
        .min_level      (min_level_reg),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_is_corner  (res_corner),
        .out_meta       (res_meta)
    );

    assign m_axis_tdata = {(fsct_pkg::OUT_DATA_W - 1 - fsct_pkg::CX_W - RW)'(0),
                           res_meta.center_y, res_meta.center_x, res_corner};
    assign m_axis_tuser = res_meta.center_valid;

    `FSCT_ASSERT_IMP(a_corner_in_valid_area,
        m_axis_tvalid && res_corner,
        res_meta.center_valid,
        "corner flagged outside the valid area")
    `FSCT_ASSERT_IMP(a_valid_centre_off_border,
        m_axis_tvalid && res_meta.center_valid,
        (res_meta.center_x >= fsct_pkg::CX_W'(fsct_pkg::RADIUS)) &&
        (res_meta.center_y >= RW'(fsct_pkg::RADIUS)),
        "valid centre inside the border")
    `FSCT_ASSERT_NEXT(a_column_below_width,
        in_fire && !cfg_valid,
        WW'(col_count_reg) < eff_w,
        "column counter past the image width")
    `FSCT_ASSERT_NEXT(a_row_monotonic,
        in_fire && !s_axis_tuser,
        row_count_reg >= $past(row_count_reg),
        "row counter went backwards within a frame")

endmodule

`default_nettype wire
